// ===== hw/rtl/rpt_pkg.sv =====
// Shared types, token and error codes for the regex pattern tokenizer.
package rpt_pkg;

    // Width of a repeat count and of the signed parenthesis depth
    localparam int COUNT_BITS = 16;
    localparam int DEPTH_BITS = 9;

    // Tokens one character can cause, and bursts the queue holds
    localparam int MAX_TOKENS  = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int TOK_IDX_W   = $clog2(MAX_TOKENS);
    localparam int TOK_CNT_W   = $clog2(MAX_TOKENS + 1);

    // Token kinds
    localparam logic [3:0] K_SYM   = 4'd0;
    localparam logic [3:0] K_ALT   = 4'd1;
    localparam logic [3:0] K_OPT   = 4'd2;
    localparam logic [3:0] K_STAR  = 4'd3;
    localparam logic [3:0] K_OPEN  = 4'd4;
    localparam logic [3:0] K_CLOSE = 4'd5;
    localparam logic [3:0] K_REP   = 4'd6;
    localparam logic [3:0] K_NAME  = 4'd7;
    localparam logic [3:0] K_ERR   = 4'd8;

    // Error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_EMPTY_CNT = 3'd1;
    localparam logic [2:0] E_BAD_CNT   = 3'd2;
    localparam logic [2:0] E_BAD_NAME  = 3'd3;
    localparam logic [2:0] E_PARENS    = 3'd4;
    localparam logic [2:0] E_OPEN_REP  = 3'd5;

    // One token, without its position within the run
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  symbol;
        logic [15:0] repeat_count;
        logic        named_group;
        logic [2:0]  error_code;
        logic        uses_named_groups;
        logic        last_of_pattern;
    } tok_t;

    // All tokens caused by one character
    typedef struct packed {
        logic [TOK_CNT_W-1:0]        cnt;
        tok_t [MAX_TOKENS-1:0]       tok;
    } burst_t;

endpackage

// ===== hw/rtl/rpt_in_if.sv =====
// Character input channel of the regex pattern tokenizer.
interface rpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_pattern;

    modport source (output valid, output ch, output end_of_pattern, input ready);
    modport sink   (input valid, input ch, input end_of_pattern, output ready);
endinterface

// ===== hw/rtl/rpt_out_if.sv =====
// Token output channel of the regex pattern tokenizer.
interface rpt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  symbol;
    logic [15:0] repeat_count;
    logic        named_group;
    logic [2:0]  error_code;
    logic        uses_named_groups;
    logic        last_of_run;
    logic        last_of_pattern;

    modport source (
        output valid, output token_kind, output symbol, output repeat_count,
        output named_group, output error_code, output uses_named_groups,
        output last_of_run, output last_of_pattern, input ready
    );
    modport sink (
        input valid, input token_kind, input symbol, input repeat_count,
        input named_group, input error_code, input uses_named_groups,
        input last_of_run, input last_of_pattern, output ready
    );
endinterface

// ===== hw/rtl/regex_pattern_tokenizer_top.sv =====
// Top level of the regex pattern tokenizer: front end, burst queue, back end.
//
//  channel    | modport | payload                                   | transfer
//  -----------+---------+-------------------------------------------+------------------
//  char_in    | sink    | ch, end_of_pattern                        | valid && ready
//  token_out  | source  | token_kind, symbol, repeat_count, ...     | valid && ready
//
// One character is taken each cycle while the burst queue (four entries) has room.
// Each character yields zero to five tokens; the back end sends one token a cycle
// while token_out.ready is high, so once the queue is full char_in waits on the output.
// Reset (rst_n low, asynchronous) clears lexer state, queue pointers and the
// output valid; no clearing pass follows. An output stall fills the queue and
// then drops char_in.ready.
module regex_pattern_tokenizer_top (
    input  logic      clk,
    input  logic      rst_n,
    rpt_in_if.sink    char_in,
    rpt_out_if.source token_out
);

    logic            q_full;
    logic            q_push;
    rpt_pkg::burst_t q_burst;
    rpt_pkg::burst_t q_head;
    logic            q_empty;
    logic            q_pop;
    rpt_pkg::tok_t   tok;

    rpt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (char_in.valid),
        .in_ready       (char_in.ready),
        .ch             (char_in.ch),
        .end_of_pattern (char_in.end_of_pattern),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_burst        (q_burst)
    );

    rpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_burst (q_burst),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    rpt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .empty           (q_empty),
        .pop             (q_pop),
        .out_valid       (token_out.valid),
        .out_ready       (token_out.ready),
        .out_tok         (tok),
        .out_last_of_run (token_out.last_of_run)
    );

    // Unpack the held token onto the output channel
    assign token_out.token_kind        = tok.token_kind;
    assign token_out.symbol            = tok.symbol;
    assign token_out.repeat_count      = tok.repeat_count;
    assign token_out.named_group       = tok.named_group;
    assign token_out.error_code        = tok.error_code;
    assign token_out.uses_named_groups = tok.uses_named_groups;
    assign token_out.last_of_pattern   = tok.last_of_pattern;

endmodule

// ===== hw/rtl/rpt_front.sv =====
// Front end: accepts characters, runs the lexer state and builds token bursts.
module rpt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      ch,
    input  logic            end_of_pattern,
    input  logic            q_full,
    output logic            q_push,
    output rpt_pkg::burst_t q_burst
);

    localparam int CW = rpt_pkg::COUNT_BITS + 4;
    localparam int DW = rpt_pkg::DEPTH_BITS;
    localparam int NCAND = 7;

    // Lexer modes
    localparam logic [1:0] M_NORMAL  = 2'd0;
    localparam logic [1:0] M_PROTECT = 2'd1;
    localparam logic [1:0] M_REPEAT  = 2'd2;
    localparam logic [1:0] M_NAME    = 2'd3;

    // Lookahead held over to the next character
    localparam logic [2:0] P_NONE  = 3'd0;
    localparam logic [2:0] P_DOT1  = 3'd1;
    localparam logic [2:0] P_DOT2  = 3'd2;
    localparam logic [2:0] P_PAREN = 3'd3;
    localparam logic [2:0] P_PCT_N = 3'd4;
    localparam logic [2:0] P_PCT_P = 3'd5;

    // Pattern characters
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // Candidate slots in emission order
    localparam int C_OUTER = 0;
    localparam int C_PEND1 = 1;
    localparam int C_PEND2 = 2;
    localparam int C_MAIN  = 3;
    localparam int C_FIN1  = 4;
    localparam int C_FIN2  = 5;
    localparam int C_LAST  = 6;

    localparam logic [DW-1:0] DEPTH_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DEPTH_MIN = {1'b1, {(DW-1){1'b0}}};

    logic [1:0]                     mode_reg, mode_next;
    logic [2:0]                     pend_reg, pend_next;
    logic [DW-1:0]                  depth_reg, depth_next;
    logic [rpt_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic                           count_seen_reg, count_seen_next;
    logic                           name_seen_reg, name_seen_next;
    logic                           started_reg, started_next;
    logic                           failed_reg, failed_next;
    logic                           named_used_reg, named_used_next;

    rpt_pkg::tok_t [NCAND-1:0] cand;
    logic [NCAND-1:0]          cand_v;
    logic                      skip_main;
    logic                      fail_now;
    logic [CW-1:0]             count_wide;
    logic [2:0]                pos;
    logic                      accept;

    function automatic rpt_pkg::tok_t mk_tok(
        input logic [3:0]  kind,
        input logic [7:0]  sym,
        input logic [15:0] cnt,
        input logic        named,
        input logic [2:0]  err,
        input logic        fin,
        input logic        uses
    );
        rpt_pkg::tok_t t;
        t.token_kind        = kind;
        t.symbol            = sym;
        t.repeat_count      = cnt;
        t.named_group       = named;
        t.error_code        = err;
        t.uses_named_groups = fin & uses;
        t.last_of_pattern   = fin;
        return t;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Scaled count with the new digit, wide enough to see overflow
    assign count_wide = (CW'(count_reg) << 3) + (CW'(count_reg) << 1)
                      + CW'(ch[3:0] - CH_0[3:0]);

    // Lexer step: pending lookahead, main character, pattern end
    always_comb
    begin
        mode_next       = mode_reg;
        pend_next       = P_NONE;
        depth_next      = depth_reg;
        count_next      = count_reg;
        count_seen_next = count_seen_reg;
        name_seen_next  = name_seen_reg;
        started_next    = 1'b1;
        failed_next     = failed_reg;
        named_used_next = named_used_reg;
        cand            = '0;
        cand_v          = '0;
        skip_main       = 1'b0;
        fail_now        = 1'b0;

        // Outer group open ahead of the first character
        if (!started_reg)
        begin
            cand_v[C_OUTER] = 1'b1;
            cand[C_OUTER]   = mk_tok(rpt_pkg::K_OPEN, 8'd0, 16'd0, 1'b0,
                                     rpt_pkg::E_NONE, 1'b0, 1'b0);
        end

        // Resolve the lookahead held from the previous character
        case (pend_reg)
            P_DOT1:
            begin
                if (ch == CH_DOT)
                begin
                    pend_next = P_DOT2;
                    skip_main = 1'b1;
                end
                else
                begin
                    cand_v[C_PEND1] = 1'b1;
                    cand[C_PEND1]   = mk_tok(rpt_pkg::K_SYM, CH_DOT, 16'd0, 1'b0,
                                             rpt_pkg::E_NONE, 1'b0, 1'b0);
                end
            end
            P_DOT2:
            begin
                cand_v[C_PEND1] = 1'b1;
                if (ch == CH_DOT)
                begin
                    cand[C_PEND1] = mk_tok(rpt_pkg::K_STAR, 8'd0, 16'd0, 1'b0,
                                           rpt_pkg::E_NONE, 1'b0, 1'b0);
                    skip_main     = 1'b1;
                end
                else
                begin
                    cand_v[C_PEND2] = 1'b1;
                    cand[C_PEND1]   = mk_tok(rpt_pkg::K_SYM, CH_DOT, 16'd0, 1'b0,
                                             rpt_pkg::E_NONE, 1'b0, 1'b0);
                    cand[C_PEND2]   = cand[C_PEND1];
                end
            end
            P_PAREN:
            begin
                if (ch == CH_LT)
                begin
                    mode_next      = M_NAME;
                    name_seen_next = 1'b0;
                    skip_main      = 1'b1;
                end
                else
                begin
                    cand_v[C_PEND1] = 1'b1;
                    cand[C_PEND1]   = mk_tok(rpt_pkg::K_OPEN, 8'd0, 16'd0, 1'b0,
                                             rpt_pkg::E_NONE, 1'b0, 1'b0);
                end
            end
            P_PCT_N:
            begin
                mode_next = M_PROTECT;
                if (ch == CH_PCT)
                begin
                    cand_v[C_PEND1] = 1'b1;
                    cand[C_PEND1]   = mk_tok(rpt_pkg::K_SYM, CH_PCT, 16'd0, 1'b0,
                                             rpt_pkg::E_NONE, 1'b0, 1'b0);
                    skip_main       = 1'b1;
                end
            end
            P_PCT_P:
            begin
                if (ch == CH_PCT)
                begin
                    cand_v[C_PEND1] = 1'b1;
                    cand[C_PEND1]   = mk_tok(rpt_pkg::K_SYM, CH_PCT, 16'd0, 1'b0,
                                             rpt_pkg::E_NONE, 1'b0, 1'b0);
                    skip_main       = 1'b1;
                end
                else
                begin
                    mode_next = M_NORMAL;
                end
            end
            default:
            begin
            end
        endcase

        // Main character in the current mode
        if (!skip_main)
        begin
            case (mode_next)
                M_REPEAT:
                begin
                    if (ch == CH_RBRACE)
                    begin
                        if (!count_seen_reg)
                        begin
                            fail_now = 1'b1;
                            cand[C_MAIN] = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0, 1'b0,
                                                  rpt_pkg::E_EMPTY_CNT, 1'b1,
                                                  named_used_reg);
                        end
                        else
                        begin
                            cand[C_MAIN] = mk_tok(rpt_pkg::K_REP, 8'd0,
                                                  16'(count_reg), 1'b0,
                                                  rpt_pkg::E_NONE, 1'b0, 1'b0);
                            mode_next    = M_NORMAL;
                        end
                        cand_v[C_MAIN] = 1'b1;
                    end
                    else if ((ch inside {[CH_0:CH_9]})
                             && !(|count_wide[CW-1:rpt_pkg::COUNT_BITS]))
                    begin
                        count_next      = count_wide[rpt_pkg::COUNT_BITS-1:0];
                        count_seen_next = 1'b1;
                    end
                    else
                    begin
                        fail_now       = 1'b1;
                        cand_v[C_MAIN] = 1'b1;
                        cand[C_MAIN]   = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0, 1'b0,
                                                rpt_pkg::E_BAD_CNT, 1'b1,
                                                named_used_reg);
                    end
                end
                M_NAME:
                begin
                    cand_v[C_MAIN] = 1'b1;
                    if (ch == CH_GT)
                    begin
                        if (!name_seen_next)
                        begin
                            fail_now     = 1'b1;
                            cand[C_MAIN] = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0, 1'b0,
                                                  rpt_pkg::E_BAD_NAME, 1'b1,
                                                  named_used_reg);
                        end
                        else
                        begin
                            named_used_next = 1'b1;
                            cand[C_MAIN]    = mk_tok(rpt_pkg::K_OPEN, 8'd0, 16'd0,
                                                     1'b1, rpt_pkg::E_NONE, 1'b0,
                                                     1'b0);
                            mode_next       = M_NORMAL;
                        end
                    end
                    else
                    begin
                        cand[C_MAIN]   = mk_tok(rpt_pkg::K_NAME, ch, 16'd0, 1'b0,
                                                rpt_pkg::E_NONE, 1'b0, 1'b0);
                        name_seen_next = 1'b1;
                    end
                end
                M_PROTECT:
                begin
                    if (ch == CH_PCT)
                    begin
                        pend_next = P_PCT_P;
                    end
                    else
                    begin
                        cand_v[C_MAIN] = 1'b1;
                        cand[C_MAIN]   = mk_tok(rpt_pkg::K_SYM, ch, 16'd0, 1'b0,
                                                rpt_pkg::E_NONE, 1'b0, 1'b0);
                    end
                end
                default:
                begin
                    case (ch)
                        CH_BAR:
                        begin
                            cand_v[C_MAIN] = 1'b1;
                            cand[C_MAIN]   = mk_tok(rpt_pkg::K_ALT, 8'd0, 16'd0, 1'b0,
                                                    rpt_pkg::E_NONE, 1'b0, 1'b0);
                        end
                        CH_QUEST:
                        begin
                            cand_v[C_MAIN] = 1'b1;
                            cand[C_MAIN]   = mk_tok(rpt_pkg::K_OPT, 8'd0, 16'd0, 1'b0,
                                                    rpt_pkg::E_NONE, 1'b0, 1'b0);
                        end
                        CH_DOT:
                        begin
                            pend_next = P_DOT1;
                        end
                        CH_LPAREN:
                        begin
                            if (depth_reg == DEPTH_MAX)
                            begin
                                fail_now       = 1'b1;
                                cand_v[C_MAIN] = 1'b1;
                                cand[C_MAIN]   = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0,
                                                        1'b0, rpt_pkg::E_PARENS, 1'b1,
                                                        named_used_reg);
                            end
                            else
                            begin
                                depth_next = depth_reg + DW'(1);
                                pend_next  = P_PAREN;
                            end
                        end
                        CH_RPAREN:
                        begin
                            cand_v[C_MAIN] = 1'b1;
                            if (depth_reg == DEPTH_MIN)
                            begin
                                fail_now     = 1'b1;
                                cand[C_MAIN] = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0,
                                                      1'b0, rpt_pkg::E_PARENS, 1'b1,
                                                      named_used_reg);
                            end
                            else
                            begin
                                depth_next   = depth_reg - DW'(1);
                                cand[C_MAIN] = mk_tok(rpt_pkg::K_CLOSE, 8'd0, 16'd0,
                                                      1'b0, rpt_pkg::E_NONE, 1'b0,
                                                      1'b0);
                            end
                        end
                        CH_LBRACE:
                        begin
                            mode_next       = M_REPEAT;
                            count_next      = '0;
                            count_seen_next = 1'b0;
                        end
                        CH_PCT:
                        begin
                            pend_next = P_PCT_N;
                        end
                        default:
                        begin
                            cand_v[C_MAIN] = 1'b1;
                            cand[C_MAIN]   = mk_tok(rpt_pkg::K_SYM, ch, 16'd0, 1'b0,
                                                    rpt_pkg::E_NONE, 1'b0, 1'b0);
                        end
                    endcase
                end
            endcase
        end

        // Pattern end: flush lookahead, then the final close or error
        if (!fail_now && end_of_pattern)
        begin
            case (pend_next)
                P_DOT1:
                begin
                    cand_v[C_FIN1] = 1'b1;
                    cand[C_FIN1]   = mk_tok(rpt_pkg::K_SYM, CH_DOT, 16'd0, 1'b0,
                                            rpt_pkg::E_NONE, 1'b0, 1'b0);
                end
                P_DOT2:
                begin
                    cand_v[C_FIN1] = 1'b1;
                    cand_v[C_FIN2] = 1'b1;
                    cand[C_FIN1]   = mk_tok(rpt_pkg::K_SYM, CH_DOT, 16'd0, 1'b0,
                                            rpt_pkg::E_NONE, 1'b0, 1'b0);
                    cand[C_FIN2]   = cand[C_FIN1];
                end
                P_PAREN:
                begin
                    cand_v[C_FIN1] = 1'b1;
                    cand[C_FIN1]   = mk_tok(rpt_pkg::K_OPEN, 8'd0, 16'd0, 1'b0,
                                            rpt_pkg::E_NONE, 1'b0, 1'b0);
                end
                default:
                begin
                end
            endcase
            cand_v[C_LAST] = 1'b1;
            if (mode_next == M_NAME)
                cand[C_LAST] = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0, 1'b0,
                                      rpt_pkg::E_BAD_NAME, 1'b1, named_used_next);
            else if (mode_next == M_REPEAT)
                cand[C_LAST] = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0, 1'b0,
                                      rpt_pkg::E_OPEN_REP, 1'b1, named_used_next);
            else if (depth_next != '0)
                cand[C_LAST] = mk_tok(rpt_pkg::K_ERR, 8'd0, 16'd0, 1'b0,
                                      rpt_pkg::E_PARENS, 1'b1, named_used_next);
            else
                cand[C_LAST] = mk_tok(rpt_pkg::K_CLOSE, 8'd0, 16'd0, 1'b0,
                                      rpt_pkg::E_NONE, 1'b1, named_used_next);
        end

        if (fail_now)
            failed_next = 1'b1;

        // Pattern end returns every register to its reset value
        if (end_of_pattern)
        begin
            mode_next       = M_NORMAL;
            pend_next       = P_NONE;
            depth_next      = '0;
            count_next      = '0;
            count_seen_next = 1'b0;
            name_seen_next  = 1'b0;
            started_next    = 1'b0;
            failed_next     = 1'b0;
            named_used_next = 1'b0;
        end
        else if (failed_reg)
        begin
            mode_next       = mode_reg;
            pend_next       = pend_reg;
            depth_next      = depth_reg;
            count_next      = count_reg;
            count_seen_next = count_seen_reg;
            name_seen_next  = name_seen_reg;
            started_next    = started_reg;
            named_used_next = named_used_reg;
        end
    end

    // Pack the valid candidates into the burst, in order
    always_comb
    begin
        q_burst = '0;
        pos     = '0;
        for (int i = 0; i < NCAND; i++)
        begin
            if (cand_v[i])
            begin
                if (32'(pos) < rpt_pkg::MAX_TOKENS)
                    q_burst.tok[pos[rpt_pkg::TOK_IDX_W-1:0]] = cand[i];
                pos = pos + 3'd1;
            end
        end
        if (32'(pos) > rpt_pkg::MAX_TOKENS)
            q_burst.cnt = rpt_pkg::TOK_CNT_W'(rpt_pkg::MAX_TOKENS);
        else
            q_burst.cnt = rpt_pkg::TOK_CNT_W'(pos);
    end

    // Push only bursts that carry tokens; nothing while skipping to pattern end
    assign q_push = accept && !failed_reg && (q_burst.cnt != '0);

    // Lexer state, advanced on each accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_NORMAL;
            pend_reg       <= P_NONE;
            depth_reg      <= '0;
            count_reg      <= '0;
            count_seen_reg <= 1'b0;
            name_seen_reg  <= 1'b0;
            started_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            named_used_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            count_seen_reg <= count_seen_next;
            name_seen_reg  <= name_seen_next;
            started_reg    <= started_next;
            failed_reg     <= failed_next;
            named_used_reg <= named_used_next;
        end
    end

endmodule

// ===== hw/rtl/rpt_queue.sv =====
// Burst queue between the front end and the token serialiser.
module rpt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rpt_pkg::burst_t push_burst,
    output logic            full,
    input  logic            pop,
    output rpt_pkg::burst_t head,
    output logic            empty
);

    localparam int AW = $clog2(rpt_pkg::QUEUE_DEPTH);
    localparam int CNTW = $clog2(rpt_pkg::QUEUE_DEPTH + 1);

    rpt_pkg::burst_t     mem [rpt_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]     count_reg, count_next;

    assign full  = (count_reg == CNTW'(rpt_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (32'(wr_ptr_reg) == rpt_pkg::QUEUE_DEPTH - 1)
                        ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (32'(rd_ptr_reg) == rpt_pkg::QUEUE_DEPTH - 1)
                        ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CNTW'(1);
        else if (pop && !push)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming burst
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_burst;
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("burst queue written while full");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("burst queue read while empty");
`endif

endmodule

// ===== hw/rtl/rpt_back.sv =====
// Back end: walks each burst and drives tokens through an output register.
module rpt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rpt_pkg::burst_t      head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rpt_pkg::tok_t        out_tok,
    output logic                 out_last_of_run
);

    logic [rpt_pkg::TOK_IDX_W-1:0] idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    rpt_pkg::tok_t                 tok_reg;
    logic                          lor_reg;
    logic                          load;
    logic                          head_last;

    assign load      = !empty && (!valid_reg || out_ready);
    assign head_last = (rpt_pkg::TOK_CNT_W'(idx_reg) + rpt_pkg::TOK_CNT_W'(1) == head.cnt);
    assign pop       = load && head_last;

    // Step through the tokens of the head burst
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = head_last ? '0 : idx_reg + rpt_pkg::TOK_IDX_W'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the token on offer until its transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg <= head.tok[idx_reg];
            lor_reg <= head_last;
        end
    end

    assign out_valid       = valid_reg;
    assign out_tok         = tok_reg;
    assign out_last_of_run = lor_reg;

`ifndef SYNTHESIS
    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rpt_pkg::TOK_CNT_W'(idx_reg) < head.cnt))
        else $error("token index beyond the head burst");
    a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && tok_reg.last_of_pattern) |-> lor_reg)
        else $error("final token of a pattern not last of its run");
`endif

endmodule

// ===== test/regex_pattern_tokenizer_top_tb.sv =====
// Self-checking testbench for the regex pattern tokenizer top level.
module regex_pattern_tokenizer_top_tb;

    // Pattern characters with a meaning to the lexer
    localparam logic [7:0] CH_BAR    = "|";
    localparam logic [7:0] CH_QUEST  = "?";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_OPEN   = "(";
    localparam logic [7:0] CH_CLOSE  = ")";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_PCT    = "%";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_LOWER_A = "a";

    localparam int     DEPTH_MAX      = (1 << (rpt_pkg::DEPTH_BITS - 1)) - 1;
    localparam int     DEPTH_MIN      = -(1 << (rpt_pkg::DEPTH_BITS - 1));
    localparam longint COUNT_MAX      = (longint'(1) << rpt_pkg::COUNT_BITS) - 1;
    localparam int     RANDOM_CHARS   = 280;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 40;

    typedef enum logic [1:0] {LEX_NORMAL, LEX_ESCAPE, LEX_REPEAT, LEX_NAME} lex_mode_t;
    typedef enum logic [2:0] {
        HOLD_NONE, HOLD_DOT1, HOLD_DOT2, HOLD_PAREN, HOLD_PCT_NORMAL, HOLD_PCT_ESCAPE
    } hold_t;

    // Token predictor and store of tokens still owed by the block
    class token_scoreboard;
        lex_mode_t      mode;
        hold_t          held;
        int             depth;
        longint         count_value;
        bit             count_seen;
        bit             name_seen;
        bit             started;
        bit             failed;
        bit             named_used;
        rpt_pkg::tok_t  burst[$];
        rpt_pkg::tok_t  expected_tokens[$];
        logic           expected_last[$];
        int             checked;
        int             mismatches;

        function new();
            clear_pattern();
            checked = 0;
            mismatches = 0;
        endfunction

        function void clear_pattern();
            mode = LEX_NORMAL;
            held = HOLD_NONE;
            depth = 0;
            count_value = 0;
            count_seen = 0;
            name_seen = 0;
            started = 0;
            failed = 0;
            named_used = 0;
        endfunction

        function void emit(logic [3:0] kind, logic [7:0] sym, longint cnt, bit named,
                           logic [2:0] err, bit closing);
            rpt_pkg::tok_t t;
            if (burst.size() >= rpt_pkg::MAX_TOKENS)
                return;
            t.token_kind        = kind;
            t.symbol            = sym;
            t.repeat_count      = 16'(cnt);
            t.named_group       = named;
            t.error_code        = err;
            t.uses_named_groups = closing && named_used;
            t.last_of_pattern   = closing;
            burst = {burst, t};
        endfunction

        function void raise_error(logic [2:0] code);
            emit(rpt_pkg::K_ERR, 8'd0, 0, 0, code, 1);
            failed = 1;
        endfunction

        // Plain character outside any lookahead or special mode
        function void lex_normal(logic [7:0] c);
            case (c)
                CH_BAR:   emit(rpt_pkg::K_ALT, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                CH_QUEST: emit(rpt_pkg::K_OPT, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                CH_DOT:   held = HOLD_DOT1;
                CH_OPEN:
                begin
                    if (depth >= DEPTH_MAX)
                    begin
                        raise_error(rpt_pkg::E_PARENS);
                    end
                    else
                    begin
                        depth++;
                        held = HOLD_PAREN;
                    end
                end
                CH_CLOSE:
                begin
                    if (depth <= DEPTH_MIN)
                    begin
                        raise_error(rpt_pkg::E_PARENS);
                    end
                    else
                    begin
                        depth--;
                        emit(rpt_pkg::K_CLOSE, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                    end
                end
                CH_LBRACE:
                begin
                    mode = LEX_REPEAT;
                    count_value = 0;
                    count_seen = 0;
                end
                CH_PCT:   held = HOLD_PCT_NORMAL;
                default:  emit(rpt_pkg::K_SYM, c, 0, 0, rpt_pkg::E_NONE, 0);
            endcase
        endfunction

        function void lex_char(logic [7:0] c);
            hold_t  p;
            longint v;
            p = held;
            held = HOLD_NONE;
            // Resolve the held lookahead first
            case (p)
                HOLD_DOT1:
                begin
                    if (c == CH_DOT)
                    begin
                        held = HOLD_DOT2;
                        return;
                    end
                    emit(rpt_pkg::K_SYM, CH_DOT, 0, 0, rpt_pkg::E_NONE, 0);
                end
                HOLD_DOT2:
                begin
                    if (c == CH_DOT)
                    begin
                        emit(rpt_pkg::K_STAR, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                        return;
                    end
                    emit(rpt_pkg::K_SYM, CH_DOT, 0, 0, rpt_pkg::E_NONE, 0);
                    emit(rpt_pkg::K_SYM, CH_DOT, 0, 0, rpt_pkg::E_NONE, 0);
                end
                HOLD_PAREN:
                begin
                    if (c == CH_LT)
                    begin
                        mode = LEX_NAME;
                        name_seen = 0;
                        return;
                    end
                    emit(rpt_pkg::K_OPEN, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                end
                HOLD_PCT_NORMAL:
                begin
                    mode = LEX_ESCAPE;
                    if (c == CH_PCT)
                    begin
                        emit(rpt_pkg::K_SYM, CH_PCT, 0, 0, rpt_pkg::E_NONE, 0);
                        return;
                    end
                end
                HOLD_PCT_ESCAPE:
                begin
                    if (c == CH_PCT)
                    begin
                        emit(rpt_pkg::K_SYM, CH_PCT, 0, 0, rpt_pkg::E_NONE, 0);
                        return;
                    end
                    mode = LEX_NORMAL;
                end
                default: ;
            endcase
            // Then the character itself, by mode
            case (mode)
                LEX_REPEAT:
                begin
                    if (c == CH_RBRACE)
                    begin
                        if (!count_seen)
                        begin
                            raise_error(rpt_pkg::E_EMPTY_CNT);
                            return;
                        end
                        emit(rpt_pkg::K_REP, 8'd0, count_value, 0, rpt_pkg::E_NONE, 0);
                        mode = LEX_NORMAL;
                    end
                    else if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        v = count_value * 10 + longint'(c - CH_ZERO);
                        if (v > COUNT_MAX)
                        begin
                            raise_error(rpt_pkg::E_BAD_CNT);
                            return;
                        end
                        count_value = v;
                        count_seen = 1;
                    end
                    else
                    begin
                        raise_error(rpt_pkg::E_BAD_CNT);
                    end
                end
                LEX_NAME:
                begin
                    if (c == CH_GT)
                    begin
                        if (!name_seen)
                        begin
                            raise_error(rpt_pkg::E_BAD_NAME);
                            return;
                        end
                        named_used = 1;
                        emit(rpt_pkg::K_OPEN, 8'd0, 0, 1, rpt_pkg::E_NONE, 0);
                        mode = LEX_NORMAL;
                    end
                    else
                    begin
                        emit(rpt_pkg::K_NAME, c, 0, 0, rpt_pkg::E_NONE, 0);
                        name_seen = 1;
                    end
                end
                LEX_ESCAPE:
                begin
                    if (c == CH_PCT)
                        held = HOLD_PCT_ESCAPE;
                    else
                        emit(rpt_pkg::K_SYM, c, 0, 0, rpt_pkg::E_NONE, 0);
                end
                default: lex_normal(c);
            endcase
        endfunction

        // Flush held lookahead and close or fail the pattern
        function void close_pattern();
            case (held)
                HOLD_DOT1: emit(rpt_pkg::K_SYM, CH_DOT, 0, 0, rpt_pkg::E_NONE, 0);
                HOLD_DOT2:
                begin
                    emit(rpt_pkg::K_SYM, CH_DOT, 0, 0, rpt_pkg::E_NONE, 0);
                    emit(rpt_pkg::K_SYM, CH_DOT, 0, 0, rpt_pkg::E_NONE, 0);
                end
                HOLD_PAREN: emit(rpt_pkg::K_OPEN, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                default: ;
            endcase
            held = HOLD_NONE;
            if (mode == LEX_NAME)
                raise_error(rpt_pkg::E_BAD_NAME);
            else if (mode == LEX_REPEAT)
                raise_error(rpt_pkg::E_OPEN_REP);
            else if (depth != 0)
                raise_error(rpt_pkg::E_PARENS);
            else
                emit(rpt_pkg::K_CLOSE, 8'd0, 0, 0, rpt_pkg::E_NONE, 1);
        endfunction

        // Note one accepted character; return 1 when the block ignores it
        function bit note_char(logic [7:0] c, logic eop);
            burst.delete();
            if (failed)
            begin
                if (eop)
                    clear_pattern();
                return 1;
            end
            if (!started)
            begin
                emit(rpt_pkg::K_OPEN, 8'd0, 0, 0, rpt_pkg::E_NONE, 0);
                started = 1;
            end
            lex_char(c);
            if (!failed && eop)
                close_pattern();
            if (eop)
                clear_pattern();
            foreach (burst[i])
            begin
                expected_tokens = {expected_tokens, burst[i]};
                expected_last = {expected_last, logic'(i == burst.size() - 1)};
            end
            return 0;
        endfunction

        task report(string what);
            $display("token %0d mismatch: %s", checked, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s is 0x%0h, want 0x%0h", name, got, want));
        endtask

        // Check one accepted token against the oldest one owed
        task check_token(rpt_pkg::tok_t got, logic got_last);
            rpt_pkg::tok_t want;
            logic want_last;
            if (expected_tokens.size() == 0)
            begin
                report($sformatf("token kind %0d arrived with none owed", got.token_kind));
                return;
            end
            want = expected_tokens.pop_front();
            want_last = expected_last.pop_front();
            compare_field("token_kind", got.token_kind, want.token_kind);
            compare_field("symbol", got.symbol, want.symbol);
            compare_field("repeat_count", got.repeat_count, want.repeat_count);
            compare_field("named_group", got.named_group, want.named_group);
            compare_field("error_code", got.error_code, want.error_code);
            compare_field("uses_named_groups", got.uses_named_groups, want.uses_named_groups);
            compare_field("last_of_run", got_last, want_last);
            compare_field("last_of_pattern", got.last_of_pattern, want.last_of_pattern);
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    rpt_in_if  char_in();
    rpt_out_if token_out();

    token_scoreboard tok_sb = new();

    int         live_chars = 0;
    int         idle_count = 0;
    int         in_idle_pct;
    int         out_stall_pct;
    logic [7:0] pattern_text[$];

    regex_pattern_tokenizer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .token_out (token_out)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: stall at random by the current percentage
    always @(posedge clk)
        token_out.ready <= ($urandom_range(0, 99) >= out_stall_pct);

    // Monitor: note input transfers, check output transfers, guard against hangs
    always @(posedge clk)
    begin
        rpt_pkg::tok_t got;
        bit            moved;
        moved = 0;
        if (char_in.valid && char_in.ready)
        begin
            if (!tok_sb.note_char(char_in.ch, char_in.end_of_pattern))
                live_chars <= live_chars + 1;
            moved = 1;
        end
        if (token_out.valid && token_out.ready)
        begin
            got.token_kind        = token_out.token_kind;
            got.symbol            = token_out.symbol;
            got.repeat_count      = token_out.repeat_count;
            got.named_group       = token_out.named_group;
            got.error_code        = token_out.error_code;
            got.uses_named_groups = token_out.uses_named_groups;
            got.last_of_pattern   = token_out.last_of_pattern;
            tok_sb.check_token(got, token_out.last_of_run);
            moved = 1;
        end
        if (moved)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic set_idling(int in_pct, int out_pct);
        in_idle_pct <= in_pct;
        out_stall_pct <= out_pct;
    endtask

    // Offer one character and hold it until the block takes it
    task automatic send_char(logic [7:0] c, logic eop);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            char_in.valid <= 1'b0;
            @(posedge clk);
        end
        char_in.valid <= 1'b1;
        char_in.ch <= c;
        char_in.end_of_pattern <= eop;
        do
            @(posedge clk);
        while (!char_in.ready);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_pattern_text();
        foreach (pattern_text[i])
            send_char(pattern_text[i], i == pattern_text.size() - 1);
    endtask

    // Add one character to the end of the pattern under construction
    function automatic void add_char(logic [7:0] c);
        pattern_text = {pattern_text, c};
    endfunction

    function automatic void append(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    // Repeat: mostly sound counts, with extremes, empty, bad and open ones
    function automatic void append_repeat();
        int pick;
        int n;
        add_char(CH_LBRACE);
        pick = $urandom_range(0, 19);
        if (pick < 2)
            append("65535");
        else if (pick < 4)
            append("65536");
        else if (pick == 4)
            n = 0;
        else
        begin
            n = $urandom_range(1, 5);
            repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            if (pick == 5)
                add_char(CH_LOWER_A + 8'($urandom_range(0, 25)));
        end
        if ($urandom_range(0, 19) != 0)
            add_char(CH_RBRACE);
    endfunction

    // Build one pattern from random fragments, mostly well formed
    function automatic void make_random_pattern();
        int frags;
        int open_groups;
        int pick;
        int n;
        pattern_text.delete();
        open_groups = 0;
        frags = $urandom_range(1, 8);
        for (int f = 0; f < frags; f++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                add_char(8'($urandom_range(0, 255)));
            end
            else if (pick < 33)
            begin
                add_char(CH_BAR);
            end
            else if (pick < 39)
            begin
                add_char(CH_QUEST);
            end
            else if (pick < 47)
            begin
                n = $urandom_range(1, 4);
                repeat (n) add_char(CH_DOT);
            end
            else if (pick < 59)
            begin
                add_char(CH_OPEN);
                open_groups++;
            end
            else if (pick < 67)
            begin
                add_char(CH_CLOSE);
                open_groups--;
            end
            else if (pick < 77)
            begin
                add_char(CH_OPEN);
                add_char(CH_LT);
                n = $urandom_range(0, 3);
                repeat (n)
                    add_char(($urandom_range(0, 3) == 0) ?
                        8'($urandom_range(0, 255)) : CH_LOWER_A + 8'($urandom_range(0, 25)));
                if ($urandom_range(0, 19) != 0)
                    add_char(CH_GT);
                open_groups++;
            end
            else if (pick < 89)
            begin
                append_repeat();
            end
            else
            begin
                add_char(CH_PCT);
                n = $urandom_range(0, 3);
                repeat (n)
                    add_char(($urandom_range(0, 3) == 0) ?
                        CH_PCT : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) != 0)
                    add_char(CH_PCT);
            end
        end
        // Balance the parentheses of most patterns
        if ($urandom_range(0, 9) != 0)
        begin
            while (open_groups > 0)
            begin
                add_char(CH_CLOSE);
                open_groups--;
            end
            while (open_groups < 0)
            begin
                add_char(CH_OPEN);
                open_groups++;
            end
        end
    endfunction

    // Stimulus and end of run
    initial
    begin
        int random_base;
        int done;
        rst_n = 1'b0;
        char_in.valid = 1'b0;
        char_in.ch = 8'd0;
        char_in.end_of_pattern = 1'b0;
        in_idle_pct = 32;
        out_stall_pct = 65;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: byte extremes, most operators and several special cases
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("...|?.");
        send_text("(<a>");
        send_text("(<>");
        send_text("(<");
        send_text("%%%%");
        send_text("{}");
        send_text("{65536}");
        send_text("{1");
        send_text("(");

        // Random patterns over three idling phases
        random_base = live_chars;
        done = 0;
        while (done < RANDOM_CHARS)
        begin
            if (done < RANDOM_CHARS / 3)
                set_idling(32, 65);
            else if (done < 2 * RANDOM_CHARS / 3)
                set_idling(65, 32);
            else
                set_idling(0, 0);
            make_random_pattern();
            send_pattern_text();
            done = live_chars - random_base;
        end
        char_in.valid <= 1'b0;

        // Drain, then settle for stray tokens
        while (tok_sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tok_sb.mismatches == 0 && tok_sb.expected_tokens.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_in_if.sv
hw/rtl/rpt_out_if.sv
hw/rtl/rpt_front.sv
hw/rtl/rpt_queue.sv
hw/rtl/rpt_back.sv
hw/rtl/regex_pattern_tokenizer_top.sv
test/regex_pattern_tokenizer_top_tb.sv
